@@ design/assert_macros.svh @@
// Assertion macros shared by the running median RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen outside reset.
`define SWM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ design/swm_pkg.sv @@
// Shared constants and types of the running median filter.
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW_DEF = 32;
  localparam int DATA_W         = 32;
  localparam int SUM_W          = 33;
  localparam int CFG_W          = 6;
  localparam int ADDR_W         = 3;
  localparam int APB_DW         = 32;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 6'd3;

  // Register index, taken from paddr bit 2 (word address).
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Status a cell hands to its upper and lower neighbors.
  typedef struct packed {
    logic gt;   // cell value above the new sample, or cell empty
    logic dbl;  // departing sample sits at this cell or below
  } swm_stat_t;

endpackage

`default_nettype wire

@@ design/swm_cell.sv @@
// One cell of the sorted window chain: holds one sample and its age.
`default_nettype none

module swm_cell #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
  parameter int IDX        = 0,
  parameter int AW         = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  parameter int WW         = $clog2(MAX_WINDOW + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             load_i,
  input  wire logic signed [swm_pkg::DATA_W-1:0] sample_i,
  input  wire logic [WW-1:0]                    base_i,
  input  wire logic                             del_en_i,
  input  wire logic [AW-1:0]                    oldest_age_i,
  input  wire logic signed [swm_pkg::DATA_W-1:0] lo_val_i,
  input  wire logic [AW-1:0]                    lo_age_i,
  input  wire swm_pkg::swm_stat_t               lo_stat_i,
  input  wire logic signed [swm_pkg::DATA_W-1:0] hi_val_i,
  input  wire logic [AW-1:0]                    hi_age_i,
  input  wire swm_pkg::swm_stat_t               hi_stat_i,
  output logic signed [swm_pkg::DATA_W-1:0]     val_o,
  output logic [AW-1:0]                         age_o,
  output swm_pkg::swm_stat_t                    stat_o
);
  import swm_pkg::*;

  logic signed [DATA_W-1:0] val_q, val_d;
  logic [AW-1:0]            age_q, age_d;
  logic                     valid;
  logic                     gt;
  logic                     del;
  logic                     dbl;
  logic                     c_gt;
  logic signed [DATA_W-1:0] c_val;
  logic [AW-1:0]            c_age;
  logic                     cm_gt;
  logic signed [DATA_W-1:0] cm_val;
  logic [AW-1:0]            cm_age;

  // Local compare against the new sample and departure check
  assign valid = (32'(base_i) > IDX);
  assign gt    = !valid || (val_q > sample_i);
  assign del   = del_en_i && valid && (age_q == oldest_age_i);
  assign dbl   = lo_stat_i.dbl || del;

  // Entry seen here once the departing sample is squeezed out
  assign c_gt  = dbl ? hi_stat_i.gt : gt;
  assign c_val = dbl ? hi_val_i : val_q;
  assign c_age = dbl ? hi_age_i : age_q;

  // Entry seen one place below after the squeeze
  assign cm_gt  = lo_stat_i.dbl ? gt : lo_stat_i.gt;
  assign cm_val = lo_stat_i.dbl ? val_q : lo_val_i;
  assign cm_age = lo_stat_i.dbl ? age_q : lo_age_i;

  // Keep, shift down from above, take the new sample, or shift up from below
  always_comb begin
    if (!c_gt) begin
      val_d = c_val;
      age_d = c_age + AW'(1);
    end else if (!cm_gt) begin
      val_d = sample_i;
      age_d = '0;
    end else begin
      val_d = cm_val;
      age_d = cm_age + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o     = val_q;
  assign age_o     = age_q;
  assign stat_o.gt = gt;
  assign stat_o.dbl = dbl;

endmodule

`default_nettype wire

@@ design/swm_tap.sv @@
// Middle-entry tap, median sum and output register of the median filter.
`default_nettype none

module swm_tap #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
  parameter int AW         = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  parameter int WW         = $clog2(MAX_WINDOW + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              take_i,
  input  wire logic [WW-1:0]                     win_i,
  input  wire logic signed [swm_pkg::DATA_W-1:0] vals_i [MAX_WINDOW],
  input  wire logic                              out_stall_i,
  output logic                                   out_valid_o,
  output logic signed [swm_pkg::SUM_W-1:0]       median_doubled_o
);
  import swm_pkg::*;

  logic [WW-1:0]           lo_pos;
  logic [WW-1:0]           hi_pos;
  logic [AW-1:0]           lo_idx;
  logic [AW-1:0]           hi_idx;
  logic signed [SUM_W-1:0] sum;
  logic                    valid_q, valid_d;
  logic signed [SUM_W-1:0] med_q;

  // Odd window: both taps hit the middle; even: the two middle entries
  assign lo_pos = (win_i - WW'(1)) >> 1;
  assign hi_pos = win_i >> 1;
  assign lo_idx = AW'(lo_pos);
  assign hi_idx = AW'(hi_pos);
  assign sum    = SUM_W'(vals_i[lo_idx]) + SUM_W'(vals_i[hi_idx]);

  // Output register: loads when free or being drained
  assign valid_d = take_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      med_q <= sum;
    end
  end

  assign out_valid_o      = valid_q;
  assign median_doubled_o = med_q;

endmodule

`default_nettype wire

@@ design/sliding_window_median_top.sv @@
// Running median filter top level: config port, cell chain and result stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries sample_i and start_req_i.
//   A beat with start_req_i high empties the window first. Once the window
//   holds window_size samples, every input beat yields one output beat on
//   (out_valid_o / out_stall_i): median_doubled_o, twice the median (sum of
//   the two middle values for an even window).
//   Throughput: one sample per cycle while in_stall_o is low; each cell of
//   the sorted chain compares, drops the departing sample and shifts in one register update.
//   Result path: the chain update is registered in the cells, then the
//   middle tap and 33-bit add load the output register.
//   Stall: a finished result waits in the output register; one more result
//   waits in the chain, and only then in_stall_o rises.
//   Reset: window empty, window_size = 3, no result pending.
//   Writing window_size (APB, address 0) empties the window; do so only
//   while no beat is in flight.
`default_nettype none
`include "assert_macros.svh"

module sliding_window_median_top #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // APB configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [swm_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [swm_pkg::APB_DW-1:0]        pwdata,
  output logic [swm_pkg::APB_DW-1:0]             prdata,
  output logic                                   pready,
  // Sample input
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [swm_pkg::DATA_W-1:0] sample_i,
  input  wire logic                              start_req_i,
  // Median output
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [swm_pkg::SUM_W-1:0]       median_doubled_o
);
  import swm_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW = $clog2(MAX_WINDOW + 1);

  logic [CFG_W-1:0]  win_size_q;
  logic [WW-1:0]     fill_q, fill_d;
  logic              pend_q, pend_d;
  logic              cfg_wr;
  logic [31:0]       ws_ext;
  logic [31:0]       w_eff32;
  logic [WW-1:0]     w_eff;
  logic [WW-1:0]     base;
  logic              full;
  logic [WW-1:0]     new_fill;
  logic              emit;
  logic              in_acc;
  logic              blocked;
  logic              take;
  logic [AW-1:0]     oldest_age;

  logic signed [DATA_W-1:0] cell_val [MAX_WINDOW];
  logic [AW-1:0]            cell_age [MAX_WINDOW];
  swm_stat_t                cell_stat [MAX_WINDOW];

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? APB_DW'(win_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WINDOW_SIZE_RST;
    end else if (cfg_wr) begin
      win_size_q <= pwdata[CFG_W-1:0];
    end
  end

  // Effective window: zero means one, capped at the chain length
  assign ws_ext  = 32'(win_size_q);
  assign w_eff32 = (ws_ext == 32'd0) ? 32'd1 :
                   (ws_ext > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : ws_ext;
  assign w_eff   = w_eff32[WW-1:0];

  // Handshake and fill tracking
  assign blocked    = out_valid_o && out_stall_i;
  assign in_stall_o = pend_q && blocked;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign take       = pend_q && !blocked;

  assign base       = start_req_i ? '0 : fill_q;
  assign full       = (base == w_eff);
  assign new_fill   = full ? w_eff : base + WW'(1);
  assign emit       = (new_fill == w_eff);
  assign oldest_age = AW'(w_eff - WW'(1));

  always_comb begin
    fill_d = fill_q;
    if (cfg_wr) begin
      fill_d = '0;
    end else if (in_acc) begin
      fill_d = new_fill;
    end
  end

  assign pend_d = in_acc ? emit : (pend_q && blocked);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pend_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      pend_q <= pend_d;
    end
  end

  // Sorted cell chain
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [DATA_W-1:0] lo_val;
    logic [AW-1:0]            lo_age;
    swm_stat_t                lo_stat;
    logic signed [DATA_W-1:0] hi_val;
    logic [AW-1:0]            hi_age;
    swm_stat_t                hi_stat;

    if (i == 0) begin : g_bot
      assign lo_val  = cell_val[i];
      assign lo_age  = cell_age[i];
      assign lo_stat = '{gt: 1'b0, dbl: 1'b0};
    end else begin : g_mid_lo
      assign lo_val  = cell_val[i-1];
      assign lo_age  = cell_age[i-1];
      assign lo_stat = cell_stat[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_top
      assign hi_val  = cell_val[i];
      assign hi_age  = cell_age[i];
      assign hi_stat = '{gt: 1'b1, dbl: 1'b1};
    end else begin : g_mid_hi
      assign hi_val  = cell_val[i+1];
      assign hi_age  = cell_age[i+1];
      assign hi_stat = cell_stat[i+1];
    end

    swm_cell #(
      .MAX_WINDOW (MAX_WINDOW),
      .IDX        (i),
      .AW         (AW),
      .WW         (WW)
    ) u_cell (
      .clk_i        (clk_i),
      .load_i       (in_acc),
      .sample_i     (sample_i),
      .base_i       (base),
      .del_en_i     (full),
      .oldest_age_i (oldest_age),
      .lo_val_i     (lo_val),
      .lo_age_i     (lo_age),
      .lo_stat_i    (lo_stat),
      .hi_val_i     (hi_val),
      .hi_age_i     (hi_age),
      .hi_stat_i    (hi_stat),
      .val_o        (cell_val[i]),
      .age_o        (cell_age[i]),
      .stat_o       (cell_stat[i])
    );
  end

  // Middle tap and output register
  swm_tap #(
    .MAX_WINDOW (MAX_WINDOW),
    .AW         (AW),
    .WW         (WW)
  ) u_tap (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .win_i            (w_eff),
    .vals_i           (cell_val),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .median_doubled_o (median_doubled_o)
  );

  // Checks
  `SWM_ASSERT(a_fill_in_window, clk_i, rst_ni, fill_q <= w_eff, "fill count above window size")
  `SWM_ASSERT(a_out_from_pend, clk_i, rst_ni, $rose(out_valid_o) |-> $past(pend_q), "result without pending beat")
  `SWM_ASSERT(a_stall_needs_pend, clk_i, rst_ni, in_stall_o |-> (pend_q && out_valid_o), "input stalled with no result waiting")
  `SWM_ASSERT(a_pend_held, clk_i, rst_ni, (pend_q && blocked) |=> (pend_q && $stable(fill_q)), "pending result lost under stall")

endmodule

`default_nettype wire

@@ verif/sliding_window_median_top_test.sv @@
// Self-checking bench for the running median filter: sorted-window predictor, APB setup.
`default_nettype none

module sliding_window_median_top_test;
  import swm_pkg::*;

  localparam int WIN_MAX    = MAX_WINDOW_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_PHASES   = 12;
  localparam int PHASE_LEN  = 62;

  typedef struct {
    logic signed [DATA_W-1:0] sample;
    logic                     start;
  } sample_beat_t;

  // DUT connections, all inputs known from time zero
  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     psel             = 1'b0;
  logic                     penable          = 1'b0;
  logic                     pwrite           = 1'b0;
  logic [ADDR_W-1:0]        paddr            = '0;
  logic [APB_DW-1:0]        pwdata           = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i       = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] sample_i         = '0;
  logic                     start_req_i      = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i      = 1'b0;
  logic signed [SUM_W-1:0]  median_doubled_o;

  // Stimulus and expected results
  sample_beat_t            sample_queue[$];
  logic signed [SUM_W-1:0] pending_medians[$];

  // Predictor state
  logic signed [DATA_W-1:0] ring_buf[WIN_MAX];
  logic signed [DATA_W-1:0] sorted_buf[WIN_MAX];
  int unsigned              fill_cnt;
  int unsigned              oldest_idx;
  logic [CFG_W-1:0]         window_reg;

  int n_samples;
  int n_medians;
  int n_cfg;
  int n_fail;
  int idle_cycles;
  int burst_left;
  int gap_left;
  int stall_cycle;
  int stall_mode;

  sliding_window_median_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Insert val into the first n sorted entries
  function automatic void sorted_put(int unsigned n, logic signed [DATA_W-1:0] val);
    int unsigned i;
    i = n;
    while (i > 0 && sorted_buf[i-1] > val) begin
      sorted_buf[i] = sorted_buf[i-1];
      i--;
    end
    sorted_buf[i] = val;
  endfunction

  // One accepted beat; returns 1 when it yields a median
  function automatic bit median_step(input logic signed [DATA_W-1:0] s, input logic st,
                                     output logic signed [SUM_W-1:0] med);
    int unsigned w;
    int unsigned i;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    w = (window_reg == 0) ? 1 : (window_reg > WIN_MAX) ? WIN_MAX : window_reg;
    med = '0;
    if (st) begin
      fill_cnt   = 0;
      oldest_idx = 0;
    end
    if (fill_cnt > w) fill_cnt = 0;
    if (oldest_idx >= w) oldest_idx = 0;
    if (fill_cnt < w) begin
      ring_buf[fill_cnt] = s;
      sorted_put(fill_cnt, s);
      fill_cnt++;
      if (fill_cnt < w) return 1'b0;
      oldest_idx = 0;
    end else begin
      // drop one copy of the departing sample, then insert the new one
      i = 0;
      while (i < w && sorted_buf[i] != ring_buf[oldest_idx]) i++;
      for (; i + 1 < w; i++) sorted_buf[i] = sorted_buf[i+1];
      sorted_put(w - 1, s);
      ring_buf[oldest_idx] = s;
      oldest_idx++;
      if (oldest_idx >= w) oldest_idx = 0;
    end
    lo  = (w % 2 == 1) ? sorted_buf[w/2] : sorted_buf[w/2 - 1];
    hi  = sorted_buf[w/2];
    med = {lo[DATA_W-1], lo} + {hi[DATA_W-1], hi};
    return 1'b1;
  endfunction

  function automatic void report_mismatch(string what, logic [SUM_W-1:0] exp_v,
                                          logic [SUM_W-1:0] act_v);
    n_fail++;
    if (n_fail <= 10)
      $display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, act_v, $realtime);
  endfunction

  function automatic void push_sample(logic signed [DATA_W-1:0] s, logic st);
    sample_beat_t b;
    b.sample = s;
    b.start  = st;
    sample_queue.insert(sample_queue.size(), b);
  endfunction

  // Random sample: mostly clean streams, some duplicates and rail values
  function automatic sample_beat_t random_beat(int start_pct);
    sample_beat_t b;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4)      b.sample = $urandom;
    else if (kind < 7) b.sample = $signed($urandom_range(0, 6)) - 3;
    else if (kind < 8) begin
      case ($urandom_range(0, 3))
        0:       b.sample = 32'sh8000_0000;
        1:       b.sample = 32'sh7FFF_FFFF;
        2:       b.sample = -32'sd1;
        default: b.sample = 32'sd0;
      endcase
    end else           b.sample = $signed($urandom_range(0, 2000)) - 1000;
    b.start = ($urandom_range(0, 99) < start_pct);
    return b;
  endfunction

  // Wait until every beat is taken and every median has come back
  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid_i || pending_medians.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of window_size followed by a read-back
  task automatic set_window(logic [CFG_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_SIZE, 2'b00};
    pwdata  <= {{(APB_DW-CFG_W){1'b0}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // write lands on this edge; window is emptied
    window_reg = val;
    fill_cnt   = 0;
    oldest_idx = 0;
    n_cfg++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[CFG_W-1:0] !== val)
      report_mismatch("window_size read", SUM_W'(val), SUM_W'(prdata[CFG_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sample driver: bursts of beats separated by random gaps
  always @(posedge clk_i) begin : drive_samples
    sample_beat_t            nxt;
    logic signed [SUM_W-1:0] med;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        n_samples++;
        if (median_step(sample_i, start_req_i, med))
          pending_medians.insert(pending_medians.size(), med);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          nxt = sample_queue.pop_front();
          in_valid_i  <= 1'b1;
          sample_i    <= nxt.sample;
          start_req_i <= nxt.start;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output stall pattern, switching between randomly chosen styles
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      2:       out_stall_i <= (stall_cycle % 5 < 2);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Median monitor and progress watchdog
  always @(posedge clk_i) begin : check_medians
    logic signed [SUM_W-1:0] exp_med;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_medians++;
        if (pending_medians.size() == 0) begin
          report_mismatch("unexpected median", '0, median_doubled_o);
        end else begin
          exp_med = pending_medians.pop_front();
          if (median_doubled_o !== exp_med)
            report_mismatch("median_doubled", exp_med, median_doubled_o);
        end
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d medians outstanding",
                 IDLE_LIMIT, pending_medians.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] wsel;
    int               start_pct;
    n_samples   = 0;
    n_medians   = 0;
    n_cfg       = 0;
    n_fail      = 0;
    idle_cycles = 0;
    burst_left  = 0;
    gap_left    = 0;
    stall_cycle = 0;
    stall_mode  = 0;
    fill_cnt    = 0;
    oldest_idx  = 0;
    window_reg  = WINDOW_SIZE_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset window of 3, rails, duplicates, restarts mid-fill and when full
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sd0, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(-32'sd1, 1'b1);
    push_sample(32'sd1, 1'b0);
    push_sample(32'sd5, 1'b1);
    push_sample(32'sh5555_5555, 1'b0);
    push_sample(32'shAAAA_AAAA, 1'b0);
    push_sample(32'sd7, 1'b0);
    push_sample(32'sd7, 1'b0);
    push_sample(32'sd7, 1'b0);
    push_sample(32'sd7, 1'b0);
    push_sample(-32'sd7, 1'b0);
    push_sample(32'sd3, 1'b1);
    push_sample(32'sd3, 1'b0);
    push_sample(32'sd2, 1'b0);
    wait_drained();

    // Random phases over several window settings, extremes first
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       wsel = 6'd32;
        1:       wsel = 6'd1;
        2:       wsel = 6'd0;
        3:       wsel = 6'd2;
        4:       wsel = 6'd63;
        5:       wsel = 6'd40;
        6:       wsel = 6'd3;
        default: wsel = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(1, 8))
                                                    : CFG_W'($urandom_range(1, 32));
      endcase
      set_window(wsel);
      start_pct = (wsel > 8) ? 1 : 4;
      for (int k = 0; k < PHASE_LEN; k++)
        sample_queue.insert(sample_queue.size(), random_beat(start_pct));
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    n_fail += pending_medians.size();
    $display("Run covered %0d samples across %0d window_size writes (0, 1, 2, 32, 63 among them)",
             n_samples, n_cfg);
    $display("%0d medians compared, %0d failures", n_medians, n_fail);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/swm_pkg.sv
design/swm_cell.sv
design/swm_tap.sv
design/sliding_window_median_top.sv
verif/sliding_window_median_top_test.sv
